>>> rtl/bbc_pkg.sv
// shared types, codes and character decode for the bracket balance checker
`default_nettype none

package bbc_pkg;

   // bracket kinds as stored on the stack
   typedef enum logic [1:0] {
      KIND_ROUND  = 2'd0,
      KIND_CURLY  = 2'd1,
      KIND_SQUARE = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   // result status codes
   typedef enum logic [2:0] {
      ST_FINE        = 3'd0,
      ST_MISMATCH    = 3'd1,
      ST_EMPTY_CLOSE = 3'd2,
      ST_OVERFLOW    = 3'd3,
      ST_UNCLOSED    = 3'd4
   } status_type;

   localparam logic [7:0] CHR_OPEN_ROUND   = 8'h28;  // (
   localparam logic [7:0] CHR_CLOSE_ROUND  = 8'h29;  // )
   localparam logic [7:0] CHR_OPEN_SQUARE  = 8'h5B;  // [
   localparam logic [7:0] CHR_CLOSE_SQUARE = 8'h5D;  // ]
   localparam logic [7:0] CHR_OPEN_CURLY   = 8'h7B;  // {
   localparam logic [7:0] CHR_CLOSE_CURLY  = 8'h7D;  // }

   localparam int unsigned DATA_W   = 8;
   localparam int unsigned RSP_W    = 16;
   localparam int unsigned DEPTH_W  = 7;

   function automatic kind_type opener_kind(input logic [7:0] c);
      kind_type k;
      case (c)
         CHR_OPEN_ROUND:  k = KIND_ROUND;
         CHR_OPEN_CURLY:  k = KIND_CURLY;
         CHR_OPEN_SQUARE: k = KIND_SQUARE;
         default:         k = KIND_NONE;
      endcase
      return k;
   endfunction

   function automatic kind_type closer_kind(input logic [7:0] c);
      kind_type k;
      case (c)
         CHR_CLOSE_ROUND:  k = KIND_ROUND;
         CHR_CLOSE_CURLY:  k = KIND_CURLY;
         CHR_CLOSE_SQUARE: k = KIND_SQUARE;
         default:          k = KIND_NONE;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

>>> rtl/bbc_stack_mem.sv
// kind stack storage: one write port, one registered read port
`default_nettype none

module bbc_stack_mem import bbc_pkg::*; #(
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire kind_type          wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output kind_type               rd_data
);

   kind_type mem [DEPTH];
   kind_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds when no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/bracket_balance_checker_core.sv
// top level of the bracket balance checker: stack control and result register
// a character's result word is registered and appears in the cycle after acceptance
// throughput: one character word per cycle while results drain, limited by the single
//    stack memory port pair (one push write or one pop read per cycle)
// the top of stack lives in a register, the entry below it is prefetched on a pop
// reset: synchronous, active high; clears the stack count, the held error and
//    the result valid; stack memory has no clearing pass and is undefined until written
`default_nettype none

module bracket_balance_checker_core import bbc_pkg::*; #(
   parameter int STACK_DEPTH = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // input words
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [DATA_W-1:0]  req_tdata,   // [7:0] char_byte
   input  wire logic               req_tlast,   // end_of_string
   // result words
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [RSP_W-1:0]        rsp_tdata,   // [2:0] status, [3] balanced,
                                                // [10:4] nesting_depth, [15:11] zero
   output logic                    rsp_tlast    // string_done
);

   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

   // stack state
   logic [CNT_W-1:0] count_ff, count_in;
   status_type       err_ff, err_in;
   kind_type         top_ff, top_in;
   // top of stack comes from the memory read data after a pop left entries
   logic             top_mem_ff, top_mem_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic             rsp_bal_ff, rsp_bal_in;
   logic [DEPTH_W-1:0] rsp_depth_ff, rsp_depth_in;
   logic             rsp_done_ff, rsp_done_in;

   // memory interface
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   kind_type          wr_data, rd_data;

   logic       in_acc;
   kind_type   open_k, close_k, top_eff;
   logic [CNT_W-1:0] cnt_below;
   logic [CNT_W+DEPTH_W-1:0] cnt_ext;

   // a new word is taken whenever the result register is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign in_acc     = req_tvalid && req_tready;

   assign open_k    = opener_kind(req_tdata);
   assign close_k   = closer_kind(req_tdata);
   assign top_eff   = top_mem_ff ? rd_data : top_ff;
   assign cnt_below = count_ff - CNT_TWO;

   always_comb begin
      count_in   = count_ff;
      err_in     = err_ff;
      top_in     = top_ff;
      top_mem_in = top_mem_ff;
      wr_en      = 1'b0;
      wr_addr    = count_ff[ADDR_W-1:0];
      wr_data    = open_k;
      rd_en      = 1'b0;
      rd_addr    = cnt_below[ADDR_W-1:0];

      if (in_acc && err_ff == ST_FINE) begin
         if (open_k != KIND_NONE) begin
            if (count_ff >= CNT_FULL) begin
               err_in = ST_OVERFLOW;
            end else begin
               wr_en      = 1'b1;
               top_in     = open_k;
               top_mem_in = 1'b0;
               count_in   = count_ff + CNT_ONE;
            end
         end else if (close_k != KIND_NONE) begin
            if (count_ff == '0) begin
               err_in = ST_EMPTY_CLOSE;
            end else begin
               count_in = count_ff - CNT_ONE;
               if (top_eff != close_k) begin
                  err_in = ST_MISMATCH;
               end
               // prefetch the entry that becomes the new top
               if (count_ff >= CNT_TWO) begin
                  rd_en      = 1'b1;
                  top_mem_in = 1'b1;
               end
            end
         end
      end

      // result of this word, taken before the end-of-string clear
      cnt_ext       = {{DEPTH_W{1'b0}}, count_in};
      rsp_depth_in  = cnt_ext[DEPTH_W-1:0];
      rsp_status_in = err_in;
      rsp_bal_in    = 1'b0;
      rsp_done_in   = req_tlast;
      if (req_tlast && err_in == ST_FINE) begin
         if (count_in != '0) begin
            rsp_status_in = ST_UNCLOSED;
         end else begin
            rsp_bal_in = 1'b1;
         end
      end

      if (in_acc && req_tlast) begin
         count_in = '0;
         err_in   = ST_FINE;
      end

      rsp_valid_in = in_acc || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         err_ff       <= ST_FINE;
         top_mem_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         err_ff       <= err_in;
         top_mem_ff   <= top_mem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (in_acc) begin
         rsp_status_ff <= rsp_status_in;
         rsp_bal_ff    <= rsp_bal_in;
         rsp_depth_ff  <= rsp_depth_in;
         rsp_done_ff   <= rsp_done_in;
      end
   end

   bbc_stack_mem #(
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W - DEPTH_W - 4){1'b0}}, rsp_depth_ff, rsp_bal_ff,
                        rsp_status_ff};
   assign rsp_tlast  = rsp_done_ff;

   // stack count never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("stack count beyond depth");

   // a held error freezes the stack until the end of the string
   a_err_freeze: assert property (@(posedge clock) disable iff (reset)
      (err_ff != ST_FINE && !(in_acc && req_tlast)) |=> $stable(count_ff))
      else $error("stack moved while an error was held");

   // end of string clears count and error
   a_end_clear: assert property (@(posedge clock) disable iff (reset)
      (in_acc && req_tlast) |=> (count_ff == '0 && err_ff == ST_FINE))
      else $error("state not cleared after end of string");

   // balanced only on a clean final word
   a_bal_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bal_ff) |-> (rsp_done_ff && rsp_status_ff == ST_FINE))
      else $error("balanced flag on a non-final or failing word");

   // memory prefetch only when an entry stays below the popped top
   a_prefetch: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (count_ff >= CNT_TWO && !wr_en))
      else $error("stack read without an entry below the top");

endmodule

`default_nettype wire
